// ===== rtl/core/nnpt_pkg.sv =====
`timescale 1ns / 1ps
package nnpt_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_DISTANCE_SQ = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MISSED_FRAMES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_MIN_FRAMES = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_IN_FRAMES   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PEOPLE        = 3'd4;

  localparam logic ACTION_ADD   = 1'b0;
  localparam logic ACTION_CLOSE = 1'b1;

  typedef struct packed {
    logic [12:0] match_distance_sq;
    logic [7:0]  max_missed_frames;
    logic [7:0]  stable_min_frames;
    logic [7:0]  count_in_frames;
    logic [3:0]  max_people;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_AGE,
    OP_PAIR,
    OP_SORT_RI,
    OP_SORT_LD,
    OP_SORT_RJ,
    OP_SORT_CMP,
    OP_SORT_WB,
    OP_MATCH_RD,
    OP_MATCH_UPD,
    OP_NEW,
    OP_COMPACT,
    OP_EMIT,
    OP_EMPTY,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AGE,
    S_PAIR,
    S_SORT_RI,
    S_SORT_LD,
    S_SORT_RJ,
    S_SORT_CMP,
    S_SORT_WB,
    S_MATCH_RD,
    S_MATCH_UPD,
    S_NEW,
    S_COMPACT,
    S_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic pair_empty;
    logic pair_last;
    logic sort_short;
    logic sort_j_last;
    logic sort_i_last;
    logic match_last;
    logic ccount_zero;
    logic new_last;
    logic tcount_zero;
    logic compact_last;
    logic stable_zero;
    logic emit_last;
  } status_t;

endpackage

// ===== rtl/core/nnpt_ctrl.sv =====
`timescale 1ns / 1ps
module nnpt_ctrl import nnpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    action,
  input  status_t st,
  output op_t     op,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACTION_CLOSE) begin
            state_next = S_AGE;
          end else begin
            op = OP_ADD;
          end
        end
      end
      S_AGE: begin
        op = OP_AGE;
        state_next = st.pair_empty ? S_NEW : S_PAIR;
      end
      S_PAIR: begin
        op = OP_PAIR;
        if (st.pair_last) state_next = S_SORT_RI;
      end
      S_SORT_RI: begin
        if (st.sort_short) begin
          state_next = S_MATCH_RD;
        end else begin
          op = OP_SORT_RI;
          state_next = S_SORT_LD;
        end
      end
      S_SORT_LD: begin
        op = OP_SORT_LD;
        state_next = S_SORT_RJ;
      end
      S_SORT_RJ: begin
        op = OP_SORT_RJ;
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        op = OP_SORT_CMP;
        state_next = st.sort_j_last ? S_SORT_WB : S_SORT_RJ;
      end
      S_SORT_WB: begin
        op = OP_SORT_WB;
        state_next = st.sort_i_last ? S_MATCH_RD : S_SORT_RI;
      end
      S_MATCH_RD: begin
        op = OP_MATCH_RD;
        state_next = S_MATCH_UPD;
      end
      S_MATCH_UPD: begin
        op = OP_MATCH_UPD;
        state_next = st.match_last ? S_NEW : S_MATCH_RD;
      end
      S_NEW: begin
        if (st.ccount_zero) begin
          state_next = S_COMPACT;
        end else begin
          op = OP_NEW;
          if (st.new_last) state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        if (st.tcount_zero) begin
          state_next = S_EMIT;
        end else begin
          op = OP_COMPACT;
          if (st.compact_last) state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.stable_zero) begin
          op = OP_EMPTY;
          state_next = S_FINISH;
        end else begin
          op = OP_EMIT;
          if (st.emit_last) state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        op = OP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/nnpt_dp.sv =====
`timescale 1ns / 1ps
module nnpt_dp import nnpt_pkg::*; #(
  parameter int MAX_TRACKS     = 8,
  parameter int MAX_COMPONENTS = 8,
  parameter int COORD_BITS     = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  op_t                   op,
  input  cfg_t                  cfg,
  input  logic [COORD_BITS-1:0] box_left,
  input  logic [COORD_BITS-1:0] box_top,
  input  logic [COORD_BITS-1:0] box_right,
  input  logic [COORD_BITS-1:0] box_bottom,
  output status_t               st,
  output logic                  strobe,
  output logic                  person_valid,
  output logic [7:0]            person_id,
  output logic [COORD_BITS-1:0] person_col,
  output logic [COORD_BITS-1:0] person_row,
  output logic [7:0]            person_duration,
  output logic [3:0]            headcount,
  output logic [15:0]           total_in,
  output logic [15:0]           total_out,
  output logic                  components_dropped,
  output logic                  last_record
);

  localparam int C         = COORD_BITS;
  localparam int TI_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TC_W      = $clog2(MAX_TRACKS + 1);
  localparam int CI_W      = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CC_W      = $clog2(MAX_COMPONENTS + 1);
  localparam int MAX_PAIRS = MAX_TRACKS * MAX_COMPONENTS;
  localparam int PI_W      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PC_W      = $clog2(MAX_PAIRS + 1);
  localparam int D_W       = 2 * C + 1;

  typedef struct packed {
    logic [7:0]   id;
    logic [C-1:0] row;
    logic [C-1:0] col;
    logic [7:0]   missed;
    logic [7:0]   dur;
    logic         counted;
  } trk_t;

  typedef struct packed {
    logic [CI_W-1:0] comp;
    logic [TI_W-1:0] trk;
    logic [D_W-1:0]  sqd;
  } pair_t;

  trk_t trk [MAX_TRACKS];
  logic [TC_W-1:0] tcount;
  logic [7:0] nid;
  logic [C-1:0] comp_row [MAX_COMPONENTS];
  logic [C-1:0] comp_col [MAX_COMPONENTS];
  logic [CC_W-1:0] ccount;
  logic overflow;
  logic [15:0] in_total;
  logic [15:0] out_total;

  logic [CI_W-1:0] pc;
  logic [TI_W-1:0] pt;
  logic [PC_W-1:0] np;
  logic [PI_W-1:0] si;
  logic [PI_W-1:0] sj;
  logic [PI_W-1:0] mi;
  pair_t cur;
  logic [MAX_COMPONENTS-1:0] cm;
  logic [MAX_TRACKS-1:0] tm;
  logic [CI_W-1:0] nc;
  logic [TI_W-1:0] ct;
  logic [TC_W-1:0] kept;
  logic [TC_W-1:0] stable_cnt;
  logic [TI_W-1:0] last_st;
  logic [TI_W-1:0] et;

  pair_t pmem [MAX_PAIRS];
  pair_t rdata;
  logic mem_we;
  logic [PI_W-1:0] waddr;
  logic [PI_W-1:0] raddr;
  pair_t wdata;

  logic [C-1:0] dr, dc;
  logic [2*C-1:0] sq_r, sq_c;
  logic [D_W-1:0] pair_sqd;
  trk_t pt_trk;
  logic swap;
  logic match_ok;
  trk_t ce, ne;
  logic drop;
  trk_t ee;
  logic [3:0] pcount;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  always_comb begin
    pt_trk = trk[pt];
    dr = (comp_row[pc] > pt_trk.row) ? comp_row[pc] - pt_trk.row : pt_trk.row - comp_row[pc];
    dc = (comp_col[pc] > pt_trk.col) ? comp_col[pc] - pt_trk.col : pt_trk.col - comp_col[pc];
    sq_r = dr * dr;
    sq_c = dc * dc;
    pair_sqd = D_W'(sq_r) + D_W'(sq_c);
  end

  assign swap = (cur.sqd > rdata.sqd);
  assign match_ok = !cm[rdata.comp] && !tm[rdata.trk] &&
                    (32'(rdata.sqd) <= 32'(cfg.match_distance_sq));

  always_comb begin
    ce = trk[ct];
    drop = (ce.missed > cfg.max_missed_frames);
    ne = ce;
    if (!ce.counted && (ce.dur > cfg.count_in_frames)) begin
      ne.counted = 1'b1;
    end
  end

  assign ee = trk[et];
  assign pcount = (32'(stable_cnt) > 32'(cfg.max_people)) ? cfg.max_people
                                                         : 4'(stable_cnt);

  always_comb begin
    mem_we = 1'b0;
    waddr = np[PI_W-1:0];
    wdata = '{comp: pc, trk: pt, sqd: pair_sqd};
    case (op)
      OP_PAIR: begin
        mem_we = 1'b1;
      end
      OP_SORT_CMP: begin
        mem_we = swap;
        waddr = sj;
        wdata = cur;
      end
      OP_SORT_WB: begin
        mem_we = 1'b1;
        waddr = si;
        wdata = cur;
      end
      default: begin
      end
    endcase
    raddr = (op == OP_SORT_RI) ? si : ((op == OP_SORT_RJ) ? sj : mi);
  end

  always_ff @(posedge clk) begin
    if (mem_we) pmem[waddr] <= wdata;
    rdata <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tcount <= '0;
      nid <= 8'd1;
      ccount <= '0;
      overflow <= 1'b0;
      in_total <= '0;
      out_total <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (op)
        OP_ADD: begin
          if (ccount < CC_W'(MAX_COMPONENTS)) begin
            comp_col[ccount[CI_W-1:0]] <= C'(({1'b0, box_left} + {1'b0, box_right}) >> 1);
            comp_row[ccount[CI_W-1:0]] <= C'(({1'b0, box_top} + {1'b0, box_bottom}) >> 1);
            ccount <= ccount + CC_W'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        OP_AGE: begin
          for (int t = 0; t < MAX_TRACKS; t++) begin
            if (TC_W'(t) < tcount) trk[t].missed <= sat_inc(trk[t].missed);
          end
          np <= '0;
          pc <= '0;
          pt <= '0;
          si <= '0;
          mi <= '0;
          nc <= '0;
          ct <= '0;
          et <= '0;
          kept <= '0;
          stable_cnt <= '0;
          last_st <= '0;
          cm <= '0;
          tm <= '0;
        end
        OP_PAIR: begin
          np <= np + PC_W'(1);
          if ((TC_W'(pt) + TC_W'(1)) == tcount) begin
            pt <= '0;
            pc <= pc + CI_W'(1);
          end else begin
            pt <= pt + TI_W'(1);
          end
        end
        OP_SORT_LD: begin
          cur <= rdata;
          sj <= si + PI_W'(1);
        end
        OP_SORT_CMP: begin
          if (swap) cur <= rdata;
          sj <= sj + PI_W'(1);
        end
        OP_SORT_WB: begin
          si <= si + PI_W'(1);
        end
        OP_MATCH_UPD: begin
          if (match_ok) begin
            cm[rdata.comp] <= 1'b1;
            tm[rdata.trk] <= 1'b1;
            trk[rdata.trk].row <= comp_row[rdata.comp];
            trk[rdata.trk].col <= comp_col[rdata.comp];
            trk[rdata.trk].missed <= '0;
            trk[rdata.trk].dur <= sat_inc(trk[rdata.trk].dur);
          end
          mi <= mi + PI_W'(1);
        end
        OP_NEW: begin
          if (!cm[nc] && (tcount < TC_W'(MAX_TRACKS))) begin
            trk[tcount[TI_W-1:0]] <= '{id: nid, row: comp_row[nc], col: comp_col[nc],
                                       missed: 8'd0, dur: 8'd1, counted: 1'b0};
            nid <= nid + 8'd1;
            tcount <= tcount + TC_W'(1);
          end
          nc <= nc + CI_W'(1);
        end
        OP_COMPACT: begin
          if (drop) begin
            if (ce.counted) out_total <= out_total + 16'd1;
            if ((TC_W'(ct) + TC_W'(1)) == tcount) tcount <= kept;
          end else begin
            if (ne.counted && !ce.counted) in_total <= in_total + 16'd1;
            trk[kept[TI_W-1:0]] <= ne;
            kept <= kept + TC_W'(1);
            if (ne.dur > cfg.stable_min_frames) begin
              stable_cnt <= stable_cnt + TC_W'(1);
              last_st <= kept[TI_W-1:0];
            end
            if ((TC_W'(ct) + TC_W'(1)) == tcount) tcount <= kept + TC_W'(1);
          end
          ct <= ct + TI_W'(1);
        end
        OP_EMIT: begin
          if (ee.dur > cfg.stable_min_frames) begin
            strobe <= 1'b1;
            person_valid <= 1'b1;
            person_id <= ee.id;
            person_col <= ee.col;
            person_row <= ee.row;
            person_duration <= ee.dur;
            headcount <= pcount;
            total_in <= in_total;
            total_out <= out_total;
            components_dropped <= overflow;
            last_record <= (et == last_st);
          end
          et <= et + TI_W'(1);
        end
        OP_EMPTY: begin
          strobe <= 1'b1;
          person_valid <= 1'b0;
          person_id <= '0;
          person_col <= '0;
          person_row <= '0;
          person_duration <= '0;
          headcount <= pcount;
          total_in <= in_total;
          total_out <= out_total;
          components_dropped <= overflow;
          last_record <= 1'b1;
        end
        OP_FINISH: begin
          ccount <= '0;
          overflow <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st.pair_empty   = (ccount == '0) || (tcount == '0);
    st.pair_last    = ((CC_W'(pc) + CC_W'(1)) == ccount) &&
                      ((TC_W'(pt) + TC_W'(1)) == tcount);
    st.sort_short   = (np <= PC_W'(1));
    st.sort_j_last  = ((PC_W'(sj) + PC_W'(1)) == np);
    st.sort_i_last  = ((PC_W'(si) + PC_W'(2)) == np);
    st.match_last   = ((PC_W'(mi) + PC_W'(1)) == np);
    st.ccount_zero  = (ccount == '0);
    st.new_last     = ((CC_W'(nc) + CC_W'(1)) == ccount);
    st.tcount_zero  = (tcount == '0);
    st.compact_last = ((TC_W'(ct) + TC_W'(1)) == tcount);
    st.stable_zero  = (stable_cnt == '0);
    st.emit_last    = ((TC_W'(et) + TC_W'(1)) == tcount);
  end

endmodule

// ===== rtl/core/nearest_neighbor_people_tracker.sv =====
`timescale 1ns / 1ps
// Nearest-neighbor people tracker.
// An input transaction is taken when start is high and busy is low. An add
// transaction (action 0) stores one box center (or flags an overflow when
// the buffer is full) and leaves busy low. A close transaction (action 1)
// raises busy while the frame is processed: aging, pairing of C components
// with T tracks (P = C*T pairs), an exchange sort of the pairs in a pair
// memory, greedy matching, track creation, compaction and reporting.
// For two or more pairs the sort dominates the time busy stays high.
// Results come out as one transaction per stable track, or a single empty
// record, each marked by strobe for one cycle; the receiver cannot stall and
// the last result is on the ports in the final busy cycle.
// Configuration writes go through cfg_valid/cfg_ready, always ready; the user
// must make them only while the block is idle, which it does not enforce.
// Synchronous reset clears all tracks, totals and the component buffer,
// sets the next track id to one, and loads the register defaults.
module nearest_neighbor_people_tracker import nnpt_pkg::*; #(
  parameter int MAX_TRACKS     = 8,
  parameter int MAX_COMPONENTS = 8,
  parameter int COORD_BITS     = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action,
  input  logic [COORD_BITS-1:0]  box_left,
  input  logic [COORD_BITS-1:0]  box_top,
  input  logic [COORD_BITS-1:0]  box_right,
  input  logic [COORD_BITS-1:0]  box_bottom,
  output logic                   strobe,
  output logic                   person_valid,
  output logic [7:0]             person_id,
  output logic [COORD_BITS-1:0]  person_col,
  output logic [COORD_BITS-1:0]  person_row,
  output logic [7:0]             person_duration,
  output logic [3:0]             headcount,
  output logic [15:0]            total_in,
  output logic [15:0]            total_out,
  output logic                   components_dropped,
  output logic                   last_record,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  op_t op;
  status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_distance_sq <= 13'd9;
      cfg.max_missed_frames <= 8'd5;
      cfg.stable_min_frames <= 8'd4;
      cfg.count_in_frames <= 8'd8;
      cfg.max_people <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MATCH_DISTANCE_SQ: cfg.match_distance_sq <= cfg_data;
        REG_MAX_MISSED_FRAMES: cfg.max_missed_frames <= cfg_data[7:0];
        REG_STABLE_MIN_FRAMES: cfg.stable_min_frames <= cfg_data[7:0];
        REG_COUNT_IN_FRAMES:   cfg.count_in_frames <= cfg_data[7:0];
        REG_MAX_PEOPLE:        cfg.max_people <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  nnpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .st     (st),
    .op     (op),
    .busy   (busy)
  );

  nnpt_dp #(
    .MAX_TRACKS     (MAX_TRACKS),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .COORD_BITS     (COORD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .op                 (op),
    .cfg                (cfg),
    .box_left           (box_left),
    .box_top            (box_top),
    .box_right          (box_right),
    .box_bottom         (box_bottom),
    .st                 (st),
    .strobe             (strobe),
    .person_valid       (person_valid),
    .person_id          (person_id),
    .person_col         (person_col),
    .person_row         (person_row),
    .person_duration    (person_duration),
    .headcount          (headcount),
    .total_in           (total_in),
    .total_out          (total_out),
    .components_dropped (components_dropped),
    .last_record        (last_record)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result strobe while idle");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !person_valid) |-> last_record) else $error("empty record not last");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (headcount <= cfg.max_people)) else $error("people count above cap");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_record) |=> !strobe) else $error("record after last record");

endmodule
